@@ src/assert_macros.svh @@
// Assertion macros shared by the rotation block RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset
`define PIPR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included
`define PIPR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/pipr_pkg.sv @@
// Types, constants and the quarter-wave sine table for the Park rotation block
`default_nettype none

package pipr_pkg;

  typedef struct packed {
    logic              req_type;
    logic signed [15:0] angle;
    logic signed [15:0] comp_x;
    logic signed [15:0] comp_y;
  } pipr_in_t;

  typedef struct packed {
    logic signed [15:0] res_x;
    logic signed [15:0] res_y;
  } pipr_out_t;

  typedef struct packed {
    logic signed [15:0] sin_val;
    logic signed [15:0] cos_val;
  } pipr_trig_t;

  // Request types
  localparam logic REQ_FORWARD = 1'b0;
  localparam logic REQ_INVERSE = 1'b1;

  // Quadrant codes taken from the top two bits of the offset angle
  localparam logic [1:0] QUAD_0_90    = 2'd2;
  localparam logic [1:0] QUAD_90_180  = 2'd3;
  localparam logic [1:0] QUAD_180_270 = 2'd0;
  localparam logic [1:0] QUAD_270_360 = 2'd1;

  // Forward output limits (most negative code is never produced)
  localparam logic signed [15:0] SAT_POS = 16'sh7FFF;
  localparam logic signed [15:0] SAT_NEG = 16'sh8001;

  // Truncation bias for division by 32768 toward zero
  localparam logic signed [31:0] Q15_BIAS = 32'sd32767;

  localparam logic [15:0] QSINE [256] = '{
    16'h0000,16'h00C9,16'h0192,16'h025B,16'h0324,16'h03ED,16'h04B6,16'h057F,
    16'h0648,16'h0711,16'h07D9,16'h08A2,16'h096A,16'h0A33,16'h0AFB,16'h0BC4,
    16'h0C8C,16'h0D54,16'h0E1C,16'h0EE3,16'h0FAB,16'h1072,16'h113A,16'h1201,
    16'h12C8,16'h138F,16'h1455,16'h151C,16'h15E2,16'h16A8,16'h176E,16'h1833,
    16'h18F9,16'h19BE,16'h1A82,16'h1B47,16'h1C0B,16'h1CCF,16'h1D93,16'h1E57,
    16'h1F1A,16'h1FDD,16'h209F,16'h2161,16'h2223,16'h22E5,16'h23A6,16'h2467,
    16'h2528,16'h25E8,16'h26A8,16'h2767,16'h2826,16'h28E5,16'h29A3,16'h2A61,
    16'h2B1F,16'h2BDC,16'h2C99,16'h2D55,16'h2E11,16'h2ECC,16'h2F87,16'h3041,
    16'h30FB,16'h31B5,16'h326E,16'h3326,16'h33DF,16'h3496,16'h354D,16'h3604,
    16'h36BA,16'h376F,16'h3824,16'h38D9,16'h398C,16'h3A40,16'h3AF2,16'h3BA5,
    16'h3C56,16'h3D07,16'h3DB8,16'h3E68,16'h3F17,16'h3FC5,16'h4073,16'h4121,
    16'h41CE,16'h427A,16'h4325,16'h43D0,16'h447A,16'h4524,16'h45CD,16'h4675,
    16'h471C,16'h47C3,16'h4869,16'h490F,16'h49B4,16'h4A58,16'h4AFB,16'h4B9D,
    16'h4C3F,16'h4CE0,16'h4D81,16'h4E20,16'h4EBF,16'h4F5D,16'h4FFB,16'h5097,
    16'h5133,16'h51CE,16'h5268,16'h5302,16'h539B,16'h5432,16'h54C9,16'h5560,
    16'h55F5,16'h568A,16'h571D,16'h57B0,16'h5842,16'h58D3,16'h5964,16'h59F3,
    16'h5A82,16'h5B0F,16'h5B9C,16'h5C28,16'h5CB3,16'h5D3E,16'h5DC7,16'h5E4F,
    16'h5ED7,16'h5F5D,16'h5FE3,16'h6068,16'h60EB,16'h616E,16'h61F0,16'h6271,
    16'h62F1,16'h6370,16'h63EE,16'h646C,16'h64E8,16'h6563,16'h65DD,16'h6656,
    16'h66CF,16'h6746,16'h67BC,16'h6832,16'h68A6,16'h6919,16'h698B,16'h69FD,
    16'h6A6D,16'h6ADC,16'h6B4A,16'h6BB7,16'h6C23,16'h6C8E,16'h6CF8,16'h6D61,
    16'h6DC9,16'h6E30,16'h6E96,16'h6EFB,16'h6F5E,16'h6FC1,16'h7022,16'h7083,
    16'h70E2,16'h7140,16'h719D,16'h71F9,16'h7254,16'h72AE,16'h7307,16'h735E,
    16'h73B5,16'h740A,16'h745F,16'h74B2,16'h7504,16'h7555,16'h75A5,16'h75F3,
    16'h7641,16'h768D,16'h76D8,16'h7722,16'h776B,16'h77B3,16'h77FA,16'h783F,
    16'h7884,16'h78C7,16'h7909,16'h794A,16'h7989,16'h79C8,16'h7A05,16'h7A41,
    16'h7A7C,16'h7AB6,16'h7AEE,16'h7B26,16'h7B5C,16'h7B91,16'h7BC5,16'h7BF8,
    16'h7C29,16'h7C59,16'h7C88,16'h7CB6,16'h7CE3,16'h7D0E,16'h7D39,16'h7D62,
    16'h7D89,16'h7DB0,16'h7DD5,16'h7DFA,16'h7E1D,16'h7E3E,16'h7E5F,16'h7E7E,
    16'h7E9C,16'h7EB9,16'h7ED5,16'h7EEF,16'h7F09,16'h7F21,16'h7F37,16'h7F4D,
    16'h7F61,16'h7F74,16'h7F86,16'h7F97,16'h7FA6,16'h7FB4,16'h7FC1,16'h7FCD,
    16'h7FD8,16'h7FE1,16'h7FE9,16'h7FF0,16'h7FF5,16'h7FF9,16'h7FFD,16'h7FFE
  };

endpackage

`default_nettype wire

@@ src/pipr_sincos.sv @@
// Sine and cosine lookup from the quarter-wave table
`default_nettype none

module pipr_sincos (
  input  wire logic signed [15:0] angle,
  output pipr_pkg::pipr_trig_t    trig
);
  import pipr_pkg::*;

  logic [9:0]         u;
  logic [7:0]         idx_i;
  logic [7:0]         idx_j;
  logic signed [15:0] ti;
  logic signed [15:0] tj;

  // Offset by half a turn: adding 32768 flips the sign bit
  assign u     = {~angle[15], angle[14:6]};
  assign idx_i = u[7:0];
  assign idx_j = ~idx_i;
  assign ti    = $signed(QSINE[idx_i]);
  assign tj    = $signed(QSINE[idx_j]);

  always_comb begin
    case (u[9:8])
      QUAD_0_90: begin
        trig.sin_val = ti;
        trig.cos_val = tj;
      end
      QUAD_90_180: begin
        trig.sin_val = tj;
        trig.cos_val = -ti;
      end
      QUAD_180_270: begin
        trig.sin_val = -ti;
        trig.cos_val = -tj;
      end
      QUAD_270_360: begin
        trig.sin_val = -tj;
        trig.cos_val = ti;
      end
      default: begin
        trig.sin_val = ti;
        trig.cos_val = tj;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ src/pipr_rotate.sv @@
// Vector rotation: four products, sums, q15 scaling and output limiting for forward requests
`default_nettype none

module pipr_rotate (
  input  wire logic               req_type,
  input  wire logic signed [15:0] comp_x,
  input  wire logic signed [15:0] comp_y,
  input  wire pipr_pkg::pipr_trig_t trig,
  output pipr_pkg::pipr_out_t     res
);
  import pipr_pkg::*;

  logic signed [31:0] p_xc;
  logic signed [31:0] p_ys;
  logic signed [31:0] p_xs;
  logic signed [31:0] p_yc;
  logic signed [31:0] sum_x;
  logic signed [31:0] sum_y;
  logic signed [16:0] q_x;
  logic signed [16:0] q_y;

  // Divide by 32768, rounding toward zero
  function automatic logic signed [16:0] scale_q15(input logic signed [31:0] s);
    logic signed [31:0] t;
    t = s + (s[31] ? Q15_BIAS : 32'sd0);
    return t[31:15];
  endfunction

  // Clamp to 16 bits and keep clear of the most negative code
  function automatic logic signed [15:0] limit_q15(input logic signed [16:0] q);
    logic signed [15:0] r;
    if (q > 17'sd32767) begin
      r = SAT_POS;
    end else if (q < -17'sd32767) begin
      r = SAT_NEG;
    end else begin
      r = q[15:0];
    end
    return r;
  endfunction

  // Magnitudes stay below 2^31, so 32-bit sums are exact
  assign p_xc = 32'(comp_x) * 32'(trig.cos_val);
  assign p_ys = 32'(comp_y) * 32'(trig.sin_val);
  assign p_xs = 32'(comp_x) * 32'(trig.sin_val);
  assign p_yc = 32'(comp_y) * 32'(trig.cos_val);

  always_comb begin
    if (req_type == REQ_INVERSE) begin
      sum_x = p_xc + p_ys;
      sum_y = p_yc - p_xs;
    end else begin
      sum_x = p_xc - p_ys;
      sum_y = p_yc + p_xs;
    end
  end

  assign q_x = scale_q15(sum_x);
  assign q_y = scale_q15(sum_y);

  always_comb begin
    if (req_type == REQ_INVERSE) begin
      res.res_x = q_x[15:0];
      res.res_y = q_y[15:0];
    end else begin
      res.res_x = limit_q15(q_x);
      res.res_y = limit_q15(q_y);
    end
  end

endmodule

`default_nettype wire

@@ src/park_inverse_park_rotation_top.sv @@
// An accepted transaction passes the input register and then the result register to out_valid.
// Throughput: one transaction per cycle unless stalled; table lookup, four 16x16 products and
// scaling sit in the single combinational pass between both registers, setting the clock period.
// Reset (rst_n low, synchronous) empties both stages; payload registers are not cleared.
// in_stall rises only when the input stage is full and the result register cannot drain.
`default_nettype none

`include "assert_macros.svh"

module park_inverse_park_rotation_top (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire pipr_pkg::pipr_in_t in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output pipr_pkg::pipr_out_t     out_data
);
  import pipr_pkg::*;

  // Input stage
  logic       in_v_r;
  logic       in_v_nxt;
  pipr_in_t   in_d_r;

  // Result stage
  logic       res_v_r;
  logic       res_v_nxt;
  pipr_out_t  res_d_r;
  logic       res_fwd_r;

  logic       in_take;
  logic       res_adv;
  pipr_trig_t trig;
  pipr_out_t  rot_res;

  // The result register may load whenever it is empty or its transaction leaves now
  assign res_adv  = !res_v_r || !out_stall;
  // Hold off the source only while the input stage is full and cannot move on
  assign in_stall = in_v_r && !res_adv;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    in_v_nxt = in_v_r;
    if (in_take) begin
      in_v_nxt = 1'b1;
    end else if (res_adv) begin
      in_v_nxt = 1'b0;
    end
  end

  assign res_v_nxt = res_adv ? in_v_r : res_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      res_v_r <= 1'b0;
    end else begin
      in_v_r  <= in_v_nxt;
      res_v_r <= res_v_nxt;
    end
  end

  // Capture the incoming transaction
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_d_r <= in_data;
    end
  end

  // Angle to sine and cosine
  pipr_sincos u_sincos (
    .angle (in_d_r.angle),
    .trig  (trig)
  );

  // Rotate, scale and limit
  pipr_rotate u_rotate (
    .req_type (in_d_r.req_type),
    .comp_x   (in_d_r.comp_x),
    .comp_y   (in_d_r.comp_y),
    .trig     (trig),
    .res      (rot_res)
  );

  // Advance the finished transaction into the result register
  always_ff @(posedge clk) begin
    if (res_adv && in_v_r) begin
      res_d_r   <= rot_res;
      res_fwd_r <= (in_d_r.req_type == REQ_FORWARD);
    end
  end

  assign out_valid = res_v_r;
  assign out_data  = res_d_r;

  `PIPR_ASSERT_ALWAYS(a_reset_empties, !rst_n |=> !out_valid && !in_stall, "reset left a stage full")
  `PIPR_ASSERT(a_stall_only_full, in_stall |-> in_v_r && out_valid, "stall without full stages")
  `PIPR_ASSERT(a_stage_moves, in_v_r && !in_stall |=> out_valid, "input stage did not advance")
  `PIPR_ASSERT(a_fwd_no_min, out_valid && res_fwd_r |-> out_data.res_x != 16'sh8000 && out_data.res_y != 16'sh8000, "forward result hit the most negative code")

endmodule

`default_nettype wire
